// ===== rtl/core/differential_steering_turn_mode_core_assert.svh =====
// Assertion macros for the steering core
`ifndef DIFFERENTIAL_STEERING_TURN_MODE_CORE_ASSERT_SVH
`define DIFFERENTIAL_STEERING_TURN_MODE_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define DST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define DST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/dstm_pkg.sv =====
// ----------------------------------------------------------------------------
// dstm_pkg
// Shared types and constants of the differential steering core.
// ----------------------------------------------------------------------------
package dstm_pkg;
  localparam int AngleIterations = 16;
  localparam int IterW = 5;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;

  // Register indexes
  localparam logic [1:0] RegNoTurn = 2'd0;
  localparam logic [1:0] RegSoft = 2'd1;
  localparam logic [1:0] RegHard = 2'd2;
  localparam logic [1:0] RegMaxSpeed = 2'd3;

  typedef enum logic [1:0] {
    ModeNone = 2'd0,
    ModeSoft = 2'd1,
    ModeHard = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    StIdle, StCordic, StSqrt, StDiv, StDone
  } state_e;

  // arctan(2^-i) in unsigned Q0.13
  function automatic logic [12:0] atan_q13(input logic [IterW-1:0] i);
    logic [12:0] r;
    unique case (i)
      5'd0: r = 13'd6434;
      5'd1: r = 13'd3798;
      5'd2: r = 13'd2007;
      5'd3: r = 13'd1019;
      5'd4: r = 13'd511;
      5'd5: r = 13'd256;
      5'd6: r = 13'd128;
      5'd7: r = 13'd64;
      5'd8: r = 13'd32;
      5'd9: r = 13'd16;
      5'd10: r = 13'd8;
      5'd11: r = 13'd4;
      5'd12: r = 13'd2;
      5'd13: r = 13'd1;
      5'd14: r = 13'd1;
      default: r = 13'd0;
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/core/dstm_if.sv =====
// ----------------------------------------------------------------------------
// dstm_in_if / dstm_out_if
// Valid/ready channels for heading items and speed items.
// ----------------------------------------------------------------------------
interface dstm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] heading_x;
  logic signed [15:0] heading_y;
  modport source (output valid, heading_x, heading_y, input ready);
  modport sink (input valid, heading_x, heading_y, output ready);
endinterface

interface dstm_out_if;
  logic valid;
  logic ready;
  logic signed [16:0] left_speed;
  logic signed [16:0] right_speed;
  logic [1:0] turn_mode;
  logic mode_entered;
  modport source (output valid, left_speed, right_speed, turn_mode, mode_entered,
                  input ready);
  modport sink (input valid, left_speed, right_speed, turn_mode, mode_entered,
                output ready);
endinterface

// ===== rtl/core/differential_steering_turn_mode_core.sv =====
// ----------------------------------------------------------------------------
// differential_steering_turn_mode_core
// Heading vector to wheel speeds with a hysteretic turn mode.
// ----------------------------------------------------------------------------
// Usage: heading items (x, y, signed Q8.8) enter on in_ch; one speed item
// (left, right, turn mode, mode entered flag) leaves on out_ch per input.
// Threshold and max speed registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write them only while the block is idle, which
// the block itself does not enforce. Each item runs the CORDIC iterations
// (one shared add/shift unit), the square root steps (one shared compare/
// subtract unit), a mode update and setup step, the restoring division
// steps and a finalize step; the result enters the output register on
// leaving finalize. in_ch.ready is high only in idle, which is entered with
// the result, so a new item is taken only after the last has left finalize.
// Reset clears the registers to their defaults and the turn mode to no turn.
// If the receiver stalls, the result waits in the output register; the next
// item is still accepted and computed, then holds in finalize until the
// waiting result is taken, and the input stays blocked meanwhile.
module differential_steering_turn_mode_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  dstm_in_if.sink     in_ch,
  dstm_out_if.source  out_ch
);
  dstm_pkg::state_e state_q, state_d;
  logic [14:0] no_q, soft_q, hard_q, max_q;
  dstm_pkg::mode_e mode_q, mode_d;
  logic [4:0] cnt_q, cnt_d;
  // CORDIC
  logic signed [18:0] x_q, x_d, y_q, y_d;
  logic signed [16:0] z_q, z_d;
  logic signed [15:0] ang_q, ang_d;
  // square root
  logic [31:0] v_q, v_d, r_q, r_d, bit_q, bit_d;
  // division
  logic [14:0] base_q, base_d;
  logic [29:0] num_q, num_d;
  logic [15:0] rem_q, rem_d;
  logic entered_q, entered_d;
  logic signed [16:0] lo_q, lo_d, hi_q, hi_d;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_q <= 15'd1789; soft_q <= 15'd5718; hard_q <= 15'd8579; max_q <= 15'd2560;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dstm_pkg::RegNoTurn: no_q <= cfg_data_i;
        dstm_pkg::RegSoft: soft_q <= cfg_data_i;
        dstm_pkg::RegHard: hard_q <= cfg_data_i;
        dstm_pkg::RegMaxSpeed: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [18:0] sx, sy;
  logic signed [16:0] zc;
  logic [31:0] sum, len_sq;
  logic [15:0] len, rem_sh;
  logic [15:0] abs_z;
  logic [14:0] base_c;
  dstm_pkg::mode_e nm;
  logic signed [16:0] dlt;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; mode_d = mode_q;
    x_d = x_q; y_d = y_q; z_d = z_q; ang_d = ang_q;
    v_d = v_q; r_d = r_q; bit_d = bit_q;
    base_d = base_q; num_d = num_q; rem_d = rem_q;
    entered_d = entered_q; lo_d = lo_q; hi_d = hi_q;
    sx = x_q >>> cnt_q; sy = y_q >>> cnt_q;
    sum = r_q + bit_q;
    zc = (z_q > 17'(dstm_pkg::PiQ13)) ? 17'(dstm_pkg::PiQ13)
       : (z_q < -17'(dstm_pkg::PiQ13)) ? -17'(dstm_pkg::PiQ13) : z_q;
    abs_z = zc[16] ? 16'(-zc) : 16'(zc);
    len = r_q[15:0];
    base_c = (len < {1'b0, max_q}) ? len[14:0] : max_q;
    rem_sh = {rem_q[14:0], num_q[29]};
    len_sq = 32'(in_ch.heading_x * in_ch.heading_x)
           + 32'(in_ch.heading_y * in_ch.heading_y);
    nm = mode_q; dlt = '0;
    unique case (state_q)
      dstm_pkg::StIdle: if (in_ch.valid) begin
        // prerotate into the right half plane
        x_d = 19'(in_ch.heading_x); y_d = 19'(in_ch.heading_y); z_d = '0;
        if (in_ch.heading_x < 0) begin
          if (in_ch.heading_y >= 0) begin
            x_d = 19'(in_ch.heading_y); y_d = -19'(in_ch.heading_x);
            z_d = 17'(dstm_pkg::HalfPiQ13);
          end else begin
            x_d = -19'(in_ch.heading_y); y_d = 19'(in_ch.heading_x);
            z_d = -17'(dstm_pkg::HalfPiQ13);
          end
        end
        if (in_ch.heading_x == 0 && in_ch.heading_y == 0) z_d = '0;
        v_d = len_sq; r_d = '0; bit_d = 32'h4000_0000;
        cnt_d = '0; state_d = dstm_pkg::StCordic;
      end
      dstm_pkg::StCordic: begin
        if (x_q == 0 && y_q == 0) begin
          // zero vector: angle stays zero
        end else if (y_q >= 0) begin
          x_d = x_q + sy; y_d = y_q - sx; z_d = z_q + 17'(dstm_pkg::atan_q13(cnt_q));
        end else begin
          x_d = x_q - sy; y_d = y_q + sx; z_d = z_q - 17'(dstm_pkg::atan_q13(cnt_q));
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(dstm_pkg::AngleIterations - 1)) begin
          cnt_d = '0; state_d = dstm_pkg::StSqrt;
        end
      end
      dstm_pkg::StSqrt: begin
        // one bit of the integer square root per cycle
        if (v_q >= sum) begin
          v_d = v_q - sum; r_d = (r_q >> 1) + bit_q;
        end else r_d = r_q >> 1;
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          cnt_d = '0; state_d = dstm_pkg::StDiv;
          ang_d = 16'(zc);
        end
      end
      dstm_pkg::StDiv: begin
        if (cnt_q == 5'd0) begin
          // mode update and setup of base*|angle| / hard
          base_d = base_c;
          if (abs_z <= {1'b0, no_q}) nm = dstm_pkg::ModeNone;
          else if (abs_z > {1'b0, hard_q}) nm = dstm_pkg::ModeHard;
          else if (abs_z > {1'b0, soft_q} && mode_q == dstm_pkg::ModeNone)
            nm = dstm_pkg::ModeSoft;
          entered_d = (nm != dstm_pkg::ModeNone) && (nm != mode_q);
          mode_d = nm;
          num_d = 30'(base_c * abs_z[14:0]); rem_d = '0;
          cnt_d = 5'd1;
        end else begin
          if (rem_sh >= {1'b0, hard_q}) begin
            rem_d = rem_sh - {1'b0, hard_q}; num_d = {num_q[28:0], 1'b1};
          end else begin
            rem_d = rem_sh; num_d = {num_q[28:0], 1'b0};
          end
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd30) state_d = dstm_pkg::StDone;
        end
      end
      dstm_pkg::StDone: begin
        // quotient fits in 15 bits since |angle| <= hard in soft turn
        if (hard_q == '0) dlt = 17'(base_q);
        else dlt = num_q[29:0] > 30'h7FFF ? 17'h7FFF : 17'(num_q[14:0]);
        unique case (mode_q)
          dstm_pkg::ModeSoft: begin lo_d = 17'(base_q) - dlt; hi_d = 17'(base_q) + dlt; end
          dstm_pkg::ModeHard: begin lo_d = -17'(max_q); hi_d = 17'(max_q); end
          default: begin lo_d = 17'(base_q); hi_d = 17'(base_q); end
        endcase
        if (!out_ch.valid || out_ch.ready) state_d = dstm_pkg::StIdle;
        else begin lo_d = lo_q; hi_d = hi_q; end
      end
      default: state_d = dstm_pkg::StIdle;
    endcase
  end

  logic ov_q;
  logic signed [15:0] oang_q;
  logic [1:0] omode_q;
  logic oent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dstm_pkg::StIdle; mode_q <= dstm_pkg::ModeNone; cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d; mode_q <= mode_d; cnt_q <= cnt_d;
      if (state_q == dstm_pkg::StDone && (!ov_q || out_ch.ready)) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; ang_q <= ang_d;
    v_q <= v_d; r_q <= r_d; bit_q <= bit_d;
    base_q <= base_d; num_q <= num_d; rem_q <= rem_d;
    entered_q <= entered_d; lo_q <= lo_d; hi_q <= hi_d;
    if (state_q == dstm_pkg::StDone && (!ov_q || out_ch.ready)) begin
      oang_q <= ang_q; omode_q <= mode_q; oent_q <= entered_q;
    end
  end

  assign in_ch.ready = (state_q == dstm_pkg::StIdle);
  assign out_ch.valid = ov_q;
  assign out_ch.left_speed = (oang_q > 0) ? lo_q : hi_q;
  assign out_ch.right_speed = (oang_q > 0) ? hi_q : lo_q;
  assign out_ch.turn_mode = omode_q;
  assign out_ch.mode_entered = oent_q;

`include "differential_steering_turn_mode_core_assert.svh"
  `DST_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ch.ready, !(state_q == dstm_pkg::StDone))
  `DST_ASSERT_IMP(a_mode_ok, clk_i, rst_ni, 1'b1, mode_q != 2'd3)
  `DST_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_ch.valid && in_ch.ready,
                  state_q == dstm_pkg::StCordic)
endmodule
